// ===== rtl/ffpa_pkg.sv =====
`default_nettype none

package ffpa_pkg;

   // Default ring size
   localparam int REQUESTERS_DEFAULT = 5;

   // Fixed field widths of the transfer payloads
   localparam int MASK_W  = 5;
   localparam int COUNT_W = 3;

   // Input transfer
   typedef struct packed {
      logic [MASK_W-1:0] release_mask;
      logic [MASK_W-1:0] finish_mask;
   } req_type;

   // Result transfer
   typedef struct packed {
      logic [MASK_W-1:0]  grant_mask;
      logic [MASK_W-1:0]  holding_mask;
      logic [MASK_W-1:0]  active_mask;
      logic [COUNT_W-1:0] waiting_count;
      logic               all_done;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic queue_step;
      logic queue_end;
      logic scan_step;
      logic release_step;
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic queue_done;
      logic scan_last;
   } ctrl_sts_type;

endpackage

`default_nettype wire

// ===== rtl/ffpa_ctrl.sv =====
`default_nettype none

module ffpa_ctrl
   import ffpa_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   output ctrl_cmd_type      cmd,
   input  wire ctrl_sts_type sts,
   output logic              rsp_valid
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_QUEUE   = 2'd1;
   localparam logic [1:0] ST_SCAN    = 2'd2;
   localparam logic [1:0] ST_RELEASE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Next state and command decode
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_QUEUE;
            end
         end
         ST_QUEUE: begin
            if (sts.queue_done) begin
               cmd.queue_end = 1'b1;
               state_in      = ST_SCAN;
            end else begin
               cmd.queue_step = 1'b1;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_RELEASE;
            end
         end
         ST_RELEASE: begin
            cmd.release_step = 1'b1;
            rsp_valid_in     = 1'b1;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/ffpa_dpath.sv =====
`default_nettype none

module ffpa_dpath
   import ffpa_pkg::*;
#(
   parameter int REQUESTERS = REQUESTERS_DEFAULT
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire req_type      req_item,
   input  wire ctrl_cmd_type cmd,
   output ctrl_sts_type      sts,
   output rsp_type           rsp_item
);

   localparam int IW = $clog2(REQUESTERS);
   localparam int CW = $clog2(REQUESTERS + 1);

   // Resource pair of one requester: its own bit and the next one round the ring
   function automatic logic [REQUESTERS-1:0] pair_of(input logic [REQUESTERS-1:0] onehot);
      return onehot | {onehot[REQUESTERS-2:0], onehot[REQUESTERS-1]};
   endfunction

   // Arbitration state
   logic [REQUESTERS-1:0] res_busy_ff, res_busy_in;
   logic [REQUESTERS-1:0] hold_ff, hold_in;
   logic [REQUESTERS-1:0] act_ff, act_in;
   logic [REQUESTERS-1:0] queued_ff, queued_in;
   logic [CW-1:0]         len_ff, len_in;
   logic [CW-1:0]         rd_ff, rd_in;
   logic [CW-1:0]         wr_ff, wr_in;
   logic [IW-1:0]         scan_ff, scan_in;

   // Per-transfer payload
   logic [REQUESTERS-1:0] rel_ff, rel_in;
   logic [REQUESTERS-1:0] fin_ff, fin_in;
   logic [REQUESTERS-1:0] grant_ff, grant_in;
   rsp_type               rsp_ff, rsp_in;

   // Waiting queue
   logic [IW-1:0] queue_ff [REQUESTERS];
   logic          q_we;
   logic [IW-1:0] q_waddr;
   logic [IW-1:0] q_wdata;

   logic [IW-1:0]         q_entry;
   logic [REQUESTERS-1:0] q_bit, q_pair;
   logic [REQUESTERS-1:0] s_bit, s_pair;
   logic [REQUESTERS-1:0] rel_set, freed, hold_rel, act_rel;
   logic [31:0]           rel_wide, fin_wide;
   logic [31:0]           grant_wide, hold_wide, act_wide;

   assign q_entry = queue_ff[rd_ff[IW-1:0]];
   assign q_bit   = REQUESTERS'(1) << q_entry;
   assign q_pair  = pair_of(q_bit);
   assign s_bit   = REQUESTERS'(1) << scan_ff;
   assign s_pair  = pair_of(s_bit);

   assign sts.queue_done = (rd_ff == len_ff);
   assign sts.scan_last  = (scan_ff == IW'(REQUESTERS - 1));

   // Release of all holders named in the masks, in parallel (pairs never overlap)
   assign rel_set  = act_ff & rel_ff & hold_ff;
   assign freed    = pair_of(rel_set);
   assign hold_rel = hold_ff & ~rel_set;
   assign act_rel  = act_ff & ~(rel_set & fin_ff);

   assign rel_wide   = 32'(req_item.release_mask);
   assign fin_wide   = 32'(req_item.finish_mask);
   assign grant_wide = 32'(grant_ff);
   assign hold_wide  = 32'(hold_rel);
   assign act_wide   = 32'(act_rel);

   // Next-state logic
   always_comb begin
      res_busy_in = res_busy_ff;
      hold_in     = hold_ff;
      act_in      = act_ff;
      queued_in   = queued_ff;
      len_in      = len_ff;
      rd_in       = rd_ff;
      wr_in       = wr_ff;
      scan_in     = scan_ff;
      rel_in      = rel_ff;
      fin_in      = fin_ff;
      grant_in    = grant_ff;
      rsp_in      = rsp_ff;
      q_we        = 1'b0;
      q_waddr     = '0;
      q_wdata     = q_entry;

      if (cmd.load) begin
         rel_in   = rel_wide[REQUESTERS-1:0];
         fin_in   = fin_wide[REQUESTERS-1:0];
         grant_in = '0;
         rd_in    = '0;
         wr_in    = '0;
         scan_in  = '0;
      end

      // Queue walk: grant or compact one entry
      if (cmd.queue_step) begin
         rd_in = rd_ff + CW'(1);
         if ((res_busy_ff & q_pair) == '0) begin
            res_busy_in = res_busy_ff | q_pair;
            hold_in     = hold_ff | q_bit;
            grant_in    = grant_ff | q_bit;
            queued_in   = queued_ff & ~q_bit;
         end else begin
            q_we    = 1'b1;
            q_waddr = wr_ff[IW-1:0];
            q_wdata = q_entry;
            wr_in   = wr_ff + CW'(1);
         end
      end

      if (cmd.queue_end) begin
         len_in = wr_ff;
      end

      // Index-order scan of one requester
      if (cmd.scan_step) begin
         scan_in = scan_ff + IW'(1);
         if ((act_ff & s_bit) != '0) begin
            if ((res_busy_ff & s_pair) == '0) begin
               res_busy_in = res_busy_ff | s_pair;
               hold_in     = hold_ff | s_bit;
               grant_in    = grant_ff | s_bit;
            end else if (((hold_ff | queued_ff) & s_bit) == '0) begin
               q_we      = 1'b1;
               q_waddr   = len_ff[IW-1:0];
               q_wdata   = scan_ff;
               queued_in = queued_ff | s_bit;
               len_in    = len_ff + CW'(1);
            end
         end
      end

      // Release and result capture
      if (cmd.release_step) begin
         res_busy_in          = res_busy_ff & ~freed;
         hold_in              = hold_rel;
         act_in               = act_rel;
         rsp_in.grant_mask    = grant_wide[MASK_W-1:0];
         rsp_in.holding_mask  = hold_wide[MASK_W-1:0];
         rsp_in.active_mask   = act_wide[MASK_W-1:0];
         rsp_in.waiting_count = COUNT_W'(len_ff);
         rsp_in.all_done      = (act_rel == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_busy_ff <= '0;
         hold_ff     <= '0;
         act_ff      <= '1;
         queued_ff   <= '0;
         len_ff      <= '0;
         rd_ff       <= '0;
         wr_ff       <= '0;
         scan_ff     <= '0;
      end else begin
         res_busy_ff <= res_busy_in;
         hold_ff     <= hold_in;
         act_ff      <= act_in;
         queued_ff   <= queued_in;
         len_ff      <= len_in;
         rd_ff       <= rd_in;
         wr_ff       <= wr_in;
         scan_ff     <= scan_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      rel_ff   <= rel_in;
      fin_ff   <= fin_in;
      grant_ff <= grant_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         queue_ff[q_waddr] <= q_wdata;
      end
   end

   assign rsp_item = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/fcfs_fork_pair_arbiter.sv =====
// First-come-first-served arbiter for a ring of REQUESTERS shared resources;
// requester i needs resources i and i+1 (mod REQUESTERS) together. Each
// transfer accepted on start (while busy is low) is one scheduling tick:
// waiting requesters are tried in queue order, then every active requester
// in index order, then the named holders release and may retire. The result
// appears on rsp_item for exactly one cycle with rsp_valid high and must be
// taken then; there is no way to stall it. The tick walks over the queue and
// then over the requesters, each walk with its own pair check; the queue
// holds at most REQUESTERS entries. busy is already low in the strobe
// cycle, so the next tick may be started there.
`default_nettype none

module fcfs_fork_pair_arbiter
   import ffpa_pkg::*;
#(
   parameter int REQUESTERS = REQUESTERS_DEFAULT
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_valid,
   output rsp_type      rsp_item
);

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   // Sequencer
   ffpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid)
   );

   // Arbitration state and queue
   ffpa_dpath #(
      .REQUESTERS (REQUESTERS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_item (rsp_item)
   );

endmodule

`default_nettype wire

// ===== rtl/ffpa_checker.sv =====
`default_nettype none

module ffpa_checker
   import ffpa_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_item
);

   // Result strobe only once the tick is over
   a_rsp_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // Strobe lasts a single cycle
   a_rsp_pulse : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // An accepted transfer starts work
   a_accept : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transfer did not start a tick");

   // Work starts only on an accepted transfer
   a_busy_cause : assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy without a start");

   // all_done implies no visible active requester
   a_all_done : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.all_done) |-> (rsp_item.active_mask == '0))
      else $error("all_done with active requesters");

endmodule

bind fcfs_fork_pair_arbiter ffpa_checker u_ffpa_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

`default_nettype wire
